// ===== hdl/fpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpcc_pkg
// Command codes, button codes and helpers shared by the console controller.
// ----------------------------------------------------------------------------
package fpcc_pkg;

  localparam int unsigned MEM_WORDS_BITS = 28;
  localparam logic [MEM_WORDS_BITS-1:0] MEM_WORDS_RESET = 28'h800_0000;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_MEMREAD  = 4'd1,
    CMD_MEMWRITE = 4'd2,
    CMD_ACCREAD  = 4'd3,
    CMD_ACCWRITE = 4'd4,
    CMD_CTRREAD  = 4'd5,
    CMD_CTRWRITE = 4'd6,
    CMD_RUN      = 4'd7,
    CMD_HALT     = 4'd8,
    CMD_STEP     = 4'd9,
    CMD_SETPC    = 4'd10
  } cmd_t;

  localparam logic KIND_PRESS = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic       REG_PANEL_LOCK   = 1'b0;
  localparam logic       REG_MEMORY_WORDS = 1'b1;

  localparam logic [4:0] BTN_DIGIT_LAST = 5'd7;
  localparam logic [4:0] BTN_ADDR       = 5'd8;
  localparam logic [4:0] BTN_CLR        = 5'd9;
  localparam logic [4:0] BTN_LOAD       = 5'd10;
  localparam logic [4:0] BTN_LOAD_INC   = 5'd11;
  localparam logic [4:0] BTN_STORE      = 5'd12;
  localparam logic [4:0] BTN_STORE_INC  = 5'd13;
  localparam logic [4:0] BTN_LDAC       = 5'd14;
  localparam logic [4:0] BTN_STAC       = 5'd15;
  localparam logic [4:0] BTN_LDCT       = 5'd16;
  localparam logic [4:0] BTN_STCT       = 5'd17;
  localparam logic [4:0] BTN_RUN        = 5'd18;
  localparam logic [4:0] BTN_HALT       = 5'd19;
  localparam logic [4:0] BTN_STEP       = 5'd20;
  localparam logic [4:0] BTN_SETPC      = 5'd21;

  typedef struct packed {
    logic                      lock;
    logic [MEM_WORDS_BITS-1:0] memory_words;
  } cfg_t;

  // remainder of a 32-bit value by a small constant modulus (2 to 16)
  function automatic logic [3:0] index_residue(input logic [31:0] value,
                                               input int unsigned modulus);
    int unsigned weight;
    logic [9:0]  sum;
    if ((modulus & (modulus - 1)) == 0) begin
      return value[3:0] & 4'(modulus - 1);
    end
    weight = 1;
    sum    = '0;
    for (int i = 0; i < 32; i++) begin
      if (value[i]) begin
        sum = sum + 10'(weight);
      end
      weight = weight * 2;
      if (weight >= modulus) begin
        weight = weight - modulus;
      end
    end
    for (int k = 8; k >= 0; k--) begin
      if ((modulus << k) < 512 && 32'(sum) >= (modulus << k)) begin
        sum = sum - 10'(modulus << k);
      end
    end
    return sum[3:0];
  endfunction

endpackage

// ===== hdl/fpcc_decode.sv =====
// ----------------------------------------------------------------------------
// fpcc_decode
// Button and read-return decode: next register values and the command.
// ----------------------------------------------------------------------------
module fpcc_decode import fpcc_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 27,
  parameter int unsigned DATA_BITS    = 36,
  parameter int unsigned ACCUMULATORS = 16,
  parameter int unsigned COUNTERS     = 8
) (
  input  logic                    kind,
  input  logic [4:0]              button,
  input  logic [DATA_BITS-1:0]    read_data,
  input  logic                    cpu_running,
  input  logic                    cpu_halted,
  input  cfg_t                    cfg,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [DATA_BITS-1:0]    data,
  output logic [ADDRESS_BITS-1:0] address_next,
  output logic [DATA_BITS-1:0]    data_next,
  output cmd_t                    command,
  output logic [ADDRESS_BITS-1:0] target,
  output logic [DATA_BITS-1:0]    write_value
);

  localparam int unsigned WIDE_BITS = (ADDRESS_BITS > DATA_BITS) ? ADDRESS_BITS : DATA_BITS;
  localparam int unsigned CMP_BITS  =
    (ADDRESS_BITS > MEM_WORDS_BITS) ? ADDRESS_BITS : MEM_WORDS_BITS;

  logic [WIDE_BITS-1:0]    data_wide;
  logic [DATA_BITS-1:0]    data_shift;
  logic [ADDRESS_BITS-1:0] step_address;
  logic                    step_in_memory;
  logic [ADDRESS_BITS-1:0] acc_index;
  logic [ADDRESS_BITS-1:0] ctr_index;

  assign data_wide  = WIDE_BITS'(data);
  assign data_shift = {data[DATA_BITS-4:0], button[2:0]};

  assign step_address = (button == BTN_LOAD_INC || button == BTN_STORE_INC) ?
                        address + ADDRESS_BITS'(1) : address;
  assign step_in_memory = CMP_BITS'(step_address) < CMP_BITS'(cfg.memory_words);

  assign acc_index = ADDRESS_BITS'(index_residue(32'(address), ACCUMULATORS));
  assign ctr_index = ADDRESS_BITS'(index_residue(32'(address), COUNTERS));

  always_comb begin
    address_next = address;
    data_next    = data;
    command      = CMD_NONE;
    target       = '0;
    write_value  = '0;
    priority if (kind == KIND_READ) begin
      data_next = read_data;
    end else if (button <= BTN_DIGIT_LAST) begin
      data_next = data_shift;
    end else begin
      unique case (button)
        BTN_ADDR: begin
          address_next = data_wide[ADDRESS_BITS-1:0];
        end
        BTN_CLR: begin
          data_next = '0;
        end
        BTN_LOAD, BTN_LOAD_INC: begin
          address_next = step_address;
          if (step_in_memory) begin
            command = CMD_MEMREAD;
            target  = step_address;
          end
        end
        BTN_STORE, BTN_STORE_INC: begin
          if (!cfg.lock) begin
            address_next = step_address;
            if (step_in_memory) begin
              command     = CMD_MEMWRITE;
              target      = step_address;
              write_value = data;
            end
          end
        end
        BTN_LDAC: begin
          command = CMD_ACCREAD;
          target  = acc_index;
        end
        BTN_STAC: begin
          if (!cfg.lock) begin
            command     = CMD_ACCWRITE;
            target      = acc_index;
            write_value = data;
          end
        end
        BTN_LDCT: begin
          command = CMD_CTRREAD;
          target  = ctr_index;
        end
        BTN_STCT: begin
          if (!cfg.lock) begin
            command     = CMD_CTRWRITE;
            target      = ctr_index;
            write_value = data;
          end
        end
        BTN_RUN: begin
          if (!cfg.lock && !cpu_running) begin
            command = CMD_RUN;
          end
        end
        BTN_HALT: begin
          if (!cfg.lock && cpu_running) begin
            command = CMD_HALT;
          end
        end
        BTN_STEP: begin
          if (!cfg.lock && cpu_halted) begin
            command = CMD_STEP;
          end
        end
        BTN_SETPC: begin
          if (!cfg.lock) begin
            command = CMD_SETPC;
            target  = address;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/front_panel_console_controller.sv =====
// ----------------------------------------------------------------------------
// front_panel_console_controller
// Operator console: address and data registers, button decode, commands.
// ----------------------------------------------------------------------------
// Takes one beat per clock while in_stall is low and returns exactly one
// result beat for each; a beat passes an input register and then the result
// register. The address and data registers are updated as a beat moves into
// the result register, so back-to-back presses see each other's effect. A
// stalled result holds the input register, and only then is the input side
// stalled.
module front_panel_console_controller import fpcc_pkg::*; #(
  parameter int unsigned ADDRESS_BITS = 27,
  parameter int unsigned DATA_BITS    = 36,
  parameter int unsigned ACCUMULATORS = 16,
  parameter int unsigned COUNTERS     = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [MEM_WORDS_BITS-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic [4:0]                button,
  input  logic [DATA_BITS-1:0]      read_data,
  input  logic                      cpu_running,
  input  logic                      cpu_halted,
  output logic                      out_valid,
  input  logic                      out_stall,
  output cmd_t                      command,
  output logic [ADDRESS_BITS-1:0]   target,
  output logic [DATA_BITS-1:0]      write_value,
  output logic [ADDRESS_BITS-1:0]   address_shown,
  output logic [DATA_BITS-1:0]      data_shown
);

  cfg_t                    cfg;
  logic [ADDRESS_BITS-1:0] address_register;
  logic [DATA_BITS-1:0]    data_register;

  logic                    s1_valid;
  logic                    s1_kind;
  logic [4:0]              s1_button;
  logic [DATA_BITS-1:0]    s1_read_data;
  logic                    s1_running;
  logic                    s1_halted;

  logic                    take;
  logic                    advance;
  logic [ADDRESS_BITS-1:0] address_next;
  logic [DATA_BITS-1:0]    data_next;
  cmd_t                    command_next;
  logic [ADDRESS_BITS-1:0] target_next;
  logic [DATA_BITS-1:0]    write_value_next;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock         <= 1'b0;
      cfg.memory_words <= MEM_WORDS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PANEL_LOCK:   cfg.lock         <= cfg_data[0];
        REG_MEMORY_WORDS: cfg.memory_words <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind      <= kind;
      s1_button    <= button;
      s1_read_data <= read_data;
      s1_running   <= cpu_running;
      s1_halted    <= cpu_halted;
    end
  end

  fpcc_decode #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .DATA_BITS    (DATA_BITS),
    .ACCUMULATORS (ACCUMULATORS),
    .COUNTERS     (COUNTERS)
  ) u_decode (
    .kind         (s1_kind),
    .button       (s1_button),
    .read_data    (s1_read_data),
    .cpu_running  (s1_running),
    .cpu_halted   (s1_halted),
    .cfg          (cfg),
    .address      (address_register),
    .data         (data_register),
    .address_next (address_next),
    .data_next    (data_next),
    .command      (command_next),
    .target       (target_next),
    .write_value  (write_value_next)
  );

  // console registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      address_register <= '0;
      data_register    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        address_register <= address_next;
        data_register    <= data_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid        <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command       <= command_next;
      target        <= target_next;
      write_value   <= write_value_next;
      address_shown <= address_next;
      data_shown    <= data_next;
    end
  end

  a_none_is_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_NONE |-> target == '0 && write_value == '0)
    else $error("beat without command carries target or value");

  a_read_no_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_MEMREAD || command == CMD_ACCREAD ||
                  command == CMD_CTRREAD) |-> write_value == '0)
    else $error("read command carries a write value");

  a_acc_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_ACCREAD || command == CMD_ACCWRITE) |->
      32'(target) < ACCUMULATORS)
    else $error("accumulator index out of range");

  a_ctr_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_CTRREAD || command == CMD_CTRWRITE) |->
      32'(target) < COUNTERS)
    else $error("counter index out of range");

endmodule
